// File: rtl/quasi_optimal_rho_psi_eval_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quasi-optimal loss evaluator
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef QUASI_OPTIMAL_RHO_PSI_EVAL_TOP_DEFINES_SVH
`define QUASI_OPTIMAL_RHO_PSI_EVAL_TOP_DEFINES_SVH

// property must hold at every edge out of reset
`define QORP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen out of reset
`define QORP_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: rtl/qorp_pkg.sv
// ----------------------------------------------------------------------------
// qorp_pkg
// Types, widths and constants shared by the quasi-optimal loss evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qorp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 24;
  localparam int CFG_WIDTH  = 23;
  localparam int LOSS_WIDTH = FRAC_BITS + 1;
  localparam int STAGES     = 15;

  // powers of u, unsigned Q.16, sized to the clamped range of u (<= 3.5)
  localparam int U_W  = 18;
  localparam int U2_W = 20;
  localparam int U3_W = 22;
  localparam int U4_W = 24;
  localparam int U5_W = 26;
  localparam int U6_W = 27;
  localparam int U7_W = 29;
  localparam int U8_W = 31;

  localparam int TERM_W = 34;
  localparam int SUM_W  = 37;
  localparam int NUM_W  = 36;
  localparam int QUO_W  = 25;
  localparam int M1_W   = 32;
  localparam int MAG_W  = 39;

  localparam int HALF_LSB = 2 ** (FRAC_BITS - 1);

  localparam logic [U_W-1:0]        U_CAP     = U_W'(7 * 2 ** (FRAC_BITS - 1));
  localparam logic [LOSS_WIDTH-1:0] LOSS_ONE  = LOSS_WIDTH'(2 ** FRAC_BITS);
  localparam logic [CFG_WIDTH-1:0]  CFG_RESET = CFG_WIDTH'(2 ** FRAC_BITS);

  // polynomial coefficients in thousandths
  localparam int C_QUAD_RHO   = 500;
  localparam int C_QUAD_SLOPE = 1000;
  localparam int C_R2 = 972;
  localparam int C_R4 = 432;
  localparam int C_R6 = 52;
  localparam int C_R8 = 2;
  localparam int C_S1 = 1944;
  localparam int C_S3 = 1728;
  localparam int C_S5 = 312;
  localparam int C_S7 = 16;
  localparam int C_C2 = 5184;
  localparam int C_C4 = 1560;
  localparam int C_C6 = 112;

  localparam logic signed [SUM_W-1:0] RHO_CONST  = SUM_W'(1792 * 2 ** FRAC_BITS);
  localparam logic signed [SUM_W-1:0] CURV_CONST = SUM_W'(1944 * 2 ** FRAC_BITS);
  localparam logic signed [SUM_W-1:0] QUAD_CURV  = SUM_W'(1000 * 2 ** FRAC_BITS);

  // rounded division by 3250: floor reciprocal 2^37/3250 plus one correction
  localparam int DIVISOR     = 3250;
  localparam int ROUND_BIAS  = DIVISOR / 2;
  localparam int DIV_RECIP_W = 26;
  localparam int DIV_SHIFT   = 37;
  localparam int DIV_SPLIT   = 18;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = DIV_RECIP_W'(42288908);

  localparam logic [DATA_WIDTH-1:0] SAT_POS = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SAT_NEG = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  localparam logic CFG_TUNING_CONST = 1'b0;
  localparam logic CFG_TUNING_RECIP = 1'b1;

  typedef enum logic [1:0] {
    REGION_QUAD = 2'd0,
    REGION_POLY = 2'd1,
    REGION_FLAT = 2'd2
  } region_e;

  typedef struct packed {
    logic    neg;
    region_e region;
  } tag_t;

  typedef struct packed {
    logic [U_W-1:0]  u;
    logic [U2_W-1:0] u2;
    logic [U3_W-1:0] u3;
    logic [U4_W-1:0] u4;
    logic [U5_W-1:0] u5;
    logic [U6_W-1:0] u6;
    logic [U7_W-1:0] u7;
    logic [U8_W-1:0] u8;
  } pow_t;

  typedef struct packed {
    logic             sign;
    logic [NUM_W-1:0] num;
  } dividend_t;

  typedef struct packed {
    dividend_t rho;
    dividend_t slope;
    dividend_t curv;
  } num_set_t;

  typedef struct packed {
    logic             sign;
    logic [QUO_W-1:0] mag;
  } quot_t;

endpackage

// File: rtl/quasi_optimal_rho_psi_eval_top.sv
// ----------------------------------------------------------------------------
// quasi_optimal_rho_psi_eval_top
// Quasi-optimal robust loss: rho, psi and curvature of one residual.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with residual_i (signed Q8.16).
// A request is taken on a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with loss_value_o, slope_value_o,
// curvature_value_o, region_o and clipped_o, one result per residual, in order.
// The result passes 15 register stages: 5 for the zone test and powers of u,
// 3 for the polynomial sums, 4 for the division by 3250 and 3 for scaling by
// 1/cc and saturation.
// Throughput is one residual per cycle unless in_stall_o is high; every stage holds a valid bit.
// When out_stall_i holds a result, upstream stages keep moving into empty
// slots; in_stall_o rises only once all 15 stages are occupied.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 cc,
// 1 reciprocal of cc); write only when the pipeline is empty.
// Reset (rst_ni low) empties the pipeline and sets both registers to 1.0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quasi_optimal_rho_psi_eval_top_defines.svh"

module quasi_optimal_rho_psi_eval_top import qorp_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] residual_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [LOSS_WIDTH-1:0]        loss_value_o,
  output logic signed [DATA_WIDTH-1:0] slope_value_o,
  output logic signed [DATA_WIDTH-1:0] curvature_value_o,
  output logic [1:0]                   region_o,
  output logic                         clipped_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]         cfg_wdata_i
);

  logic [CFG_WIDTH-1:0] tuning_const_q, tuning_recip_q;
  logic [STAGES:1]      valid_q;
  logic [STAGES:1]      en;

  tag_t     pow_tag, poly_tag;
  tag_t     tag9_q, tag10_q, tag11_q, tag12_q;
  pow_t     pow;
  num_set_t nums;
  quot_t    rho_quot, slope_quot, curv_quot;
  region_e  region;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_const_q <= CFG_RESET;
      tuning_recip_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TUNING_CONST: tuning_const_q <= cfg_wdata_i;
        CFG_TUNING_RECIP: tuning_recip_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // a stage holds only when it and everything after it is full and stalled
  for (genvar g = 1; g <= STAGES; g++) begin : g_stage
    assign en[g] = !(out_stall_i && (&valid_q[STAGES:g]));

    if (g == 1) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[g] <= 1'b0;
        end else if (en[g]) begin
          valid_q[g] <= in_valid_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[g] <= 1'b0;
        end else if (en[g]) begin
          valid_q[g] <= valid_q[g-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = valid_q[STAGES];

  qorp_power_pipe u_power (
    .clk_i          (clk_i),
    .en_i           (en[5:1]),
    .residual_i     (residual_i),
    .tuning_const_i (tuning_const_q),
    .tuning_recip_i (tuning_recip_q),
    .tag_o          (pow_tag),
    .pow_o          (pow)
  );

  qorp_poly_sum u_poly (
    .clk_i  (clk_i),
    .en_i   (en[8:6]),
    .tag_i  (pow_tag),
    .pow_i  (pow),
    .tag_o  (poly_tag),
    .nums_o (nums)
  );

  qorp_div_lane u_div_rho (
    .clk_i  (clk_i),
    .en_i   (en[12:9]),
    .num_i  (nums.rho),
    .quot_o (rho_quot)
  );

  qorp_div_lane u_div_slope (
    .clk_i  (clk_i),
    .en_i   (en[12:9]),
    .num_i  (nums.slope),
    .quot_o (slope_quot)
  );

  qorp_div_lane u_div_curv (
    .clk_i  (clk_i),
    .en_i   (en[12:9]),
    .num_i  (nums.curv),
    .quot_o (curv_quot)
  );

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      tag9_q <= poly_tag;
    end
    if (en[10]) begin
      tag10_q <= tag9_q;
    end
    if (en[11]) begin
      tag11_q <= tag10_q;
    end
    if (en[12]) begin
      tag12_q <= tag11_q;
    end
  end

  qorp_scale_out u_scale (
    .clk_i             (clk_i),
    .en_i              (en[15:13]),
    .tag_i             (tag12_q),
    .rho_i             (rho_quot),
    .slope_i           (slope_quot),
    .curv_i            (curv_quot),
    .tuning_recip_i    (tuning_recip_q),
    .loss_value_o      (loss_value_o),
    .slope_value_o     (slope_value_o),
    .curvature_value_o (curvature_value_o),
    .region_o          (region),
    .clipped_o         (clipped_o)
  );

  assign region_o = region;

  `QORP_ASSERT(a_stall_only_when_full, in_stall_o |-> (&valid_q), "input stalled with a free stage")
  `QORP_ASSERT(a_flat_result, (out_valid_o && region_o == REGION_FLAT) |-> (loss_value_o == LOSS_ONE && slope_value_o == '0 && curvature_value_o == '0 && !clipped_o), "flat zone result not constant")
  `QORP_ASSERT_NEVER(a_loss_range, out_valid_o && loss_value_o > LOSS_ONE, "loss above one")
  `QORP_ASSERT(a_clip_at_limit, (out_valid_o && clipped_o) |-> (slope_value_o == SAT_POS || slope_value_o == SAT_NEG || curvature_value_o == SAT_POS || curvature_value_o == SAT_NEG), "clip flag without a saturated value")

endmodule

// File: rtl/qorp_power_pipe.sv
// ----------------------------------------------------------------------------
// qorp_power_pipe
// Zone decision, scaled residual u and its powers up to u^8 (five stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qorp_power_pipe import qorp_pkg::*; (
  input  logic                         clk_i,
  input  logic [4:0]                   en_i,
  input  logic signed [DATA_WIDTH-1:0] residual_i,
  input  logic [CFG_WIDTH-1:0]         tuning_const_i,
  input  logic [CFG_WIDTH-1:0]         tuning_recip_i,
  output tag_t                         tag_o,
  output pow_t                         pow_o
);

  localparam int UX_W = DATA_WIDTH + CFG_WIDTH;
  localparam int TH_W = CFG_WIDTH + 2;

  logic                  neg_w;
  logic [DATA_WIDTH-1:0] ax_w;
  logic [TH_W-1:0]       ax_ext_w, two_cc_w, three_cc_w;
  region_e               region_w;
  logic [UX_W-1:0]       ux_prod_w;
  logic [UX_W-FRAC_BITS-1:0] ux_shift_w;
  logic [U_W-1:0]        u_w;
  logic [2*U_W-1:0]      sq_w;
  logic [U2_W+U_W-1:0]   p3_w;
  logic [2*U2_W-1:0]     p4_w;
  logic [U4_W+U_W-1:0]   p5_w;
  logic [U4_W+U2_W-1:0]  p6_w;
  logic [U4_W+U3_W-1:0]  p7_w;
  logic [2*U4_W-1:0]     p8_w;

  tag_t                  tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic [DATA_WIDTH-1:0] ax1_q;
  logic [U_W-1:0]        u2s_q, u3s_q, u4s_q, u5s_q;
  logic [U2_W-1:0]       sq3_q, sq4_q, sq5_q;
  logic [U3_W-1:0]       cb4_q, cb5_q;
  logic [U4_W-1:0]       qd4_q, qd5_q;
  logic [U5_W-1:0]       u5_q;
  logic [U6_W-1:0]       u6_q;
  logic [U7_W-1:0]       u7_q;
  logic [U8_W-1:0]       u8_q;

  // stage 1: magnitude and zone
  always_comb begin
    neg_w      = residual_i[DATA_WIDTH-1];
    ax_w       = neg_w ? (~$unsigned(residual_i) + DATA_WIDTH'(1)) : $unsigned(residual_i);
    ax_ext_w   = TH_W'(ax_w);
    two_cc_w   = {1'b0, tuning_const_i, 1'b0};
    three_cc_w = TH_W'(tuning_const_i) + two_cc_w;
    if (ax_ext_w <= two_cc_w) begin
      region_w = REGION_QUAD;
    end else if (ax_ext_w <= three_cc_w) begin
      region_w = REGION_POLY;
    end else begin
      region_w = REGION_FLAT;
    end
  end

  // stage 2: u = |x| times the reciprocal register of cc, clamped to 3.5
  always_comb begin
    ux_prod_w  = UX_W'(ax1_q) * UX_W'(tuning_recip_i) + UX_W'(HALF_LSB);
    ux_shift_w = ux_prod_w[UX_W-1:FRAC_BITS];
    u_w = (ux_shift_w > (UX_W-FRAC_BITS)'(U_CAP)) ? U_CAP : ux_shift_w[U_W-1:0];
  end

  always_comb begin
    sq_w = (2*U_W)'(u2s_q) * (2*U_W)'(u2s_q) + (2*U_W)'(HALF_LSB);
    p3_w = (U2_W+U_W)'(sq3_q) * (U2_W+U_W)'(u3s_q) + (U2_W+U_W)'(HALF_LSB);
    p4_w = (2*U2_W)'(sq3_q) * (2*U2_W)'(sq3_q) + (2*U2_W)'(HALF_LSB);
    p5_w = (U4_W+U_W)'(qd4_q) * (U4_W+U_W)'(u4s_q) + (U4_W+U_W)'(HALF_LSB);
    p6_w = (U4_W+U2_W)'(qd4_q) * (U4_W+U2_W)'(sq4_q) + (U4_W+U2_W)'(HALF_LSB);
    p7_w = (U4_W+U3_W)'(qd4_q) * (U4_W+U3_W)'(cb4_q) + (U4_W+U3_W)'(HALF_LSB);
    p8_w = (2*U4_W)'(qd4_q) * (2*U4_W)'(qd4_q) + (2*U4_W)'(HALF_LSB);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tag1_q <= '{neg: neg_w, region: region_w};
      ax1_q  <= ax_w;
    end
    if (en_i[1]) begin
      tag2_q <= tag1_q;
      u2s_q  <= u_w;
    end
    if (en_i[2]) begin
      tag3_q <= tag2_q;
      u3s_q  <= u2s_q;
      sq3_q  <= sq_w[FRAC_BITS +: U2_W];
    end
    if (en_i[3]) begin
      tag4_q <= tag3_q;
      u4s_q  <= u3s_q;
      sq4_q  <= sq3_q;
      cb4_q  <= p3_w[FRAC_BITS +: U3_W];
      qd4_q  <= p4_w[FRAC_BITS +: U4_W];
    end
    if (en_i[4]) begin
      tag5_q <= tag4_q;
      u5s_q  <= u4s_q;
      sq5_q  <= sq4_q;
      cb5_q  <= cb4_q;
      qd5_q  <= qd4_q;
      u5_q   <= p5_w[FRAC_BITS +: U5_W];
      u6_q   <= p6_w[FRAC_BITS +: U6_W];
      u7_q   <= p7_w[FRAC_BITS +: U7_W];
      u8_q   <= p8_w[FRAC_BITS +: U8_W];
    end
  end

  assign tag_o = tag5_q;
  assign pow_o = '{u: u5s_q, u2: sq5_q, u3: cb5_q, u4: qd5_q,
                   u5: u5_q, u6: u6_q, u7: u7_q, u8: u8_q};

endmodule

// File: rtl/qorp_poly_sum.sv
// ----------------------------------------------------------------------------
// qorp_poly_sum
// Coefficient terms, zone sums and rounding bias for the three numerators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qorp_poly_sum import qorp_pkg::*; (
  input  logic       clk_i,
  input  logic [2:0] en_i,
  input  tag_t       tag_i,
  input  pow_t       pow_i,
  output tag_t       tag_o,
  output num_set_t   nums_o
);

  tag_t tag6_q, tag7_q, tag8_q;

  logic [TERM_W-1:0] qr_q, qs_q;
  logic [TERM_W-1:0] r2_q, r4_q, r6_q, r8_q;
  logic [TERM_W-1:0] s1_q, s3_q, s5_q, s7_q;
  logic [TERM_W-1:0] c2_q, c4_q, c6_q;

  logic signed [SUM_W-1:0] sr_w, ss_w, sc_w;
  logic signed [SUM_W-1:0] sr_q, ss_q, sc_q;
  num_set_t                nums_w;
  num_set_t                nums_q;

  function automatic dividend_t bias_sm(input logic signed [SUM_W-1:0] s);
    logic             neg;
    logic [SUM_W-1:0] sel;
    logic [SUM_W-1:0] sum;
    neg = s[SUM_W-1];
    sel = neg ? ~$unsigned(s) : $unsigned(s);
    sum = sel + SUM_W'(neg ? ROUND_BIAS + 1 : ROUND_BIAS);
    return '{sign: neg, num: sum[NUM_W-1:0]};
  endfunction

  always_comb begin
    if (tag6_q.region == REGION_QUAD) begin
      sr_w = $signed(SUM_W'(qr_q));
      ss_w = $signed(SUM_W'(qs_q));
      sc_w = QUAD_CURV;
    end else begin
      sr_w = RHO_CONST - $signed(SUM_W'(r2_q)) + $signed(SUM_W'(r4_q))
           - $signed(SUM_W'(r6_q)) + $signed(SUM_W'(r8_q));
      ss_w = $signed(SUM_W'(s3_q)) - $signed(SUM_W'(s1_q))
           - $signed(SUM_W'(s5_q)) + $signed(SUM_W'(s7_q));
      sc_w = $signed(SUM_W'(c2_q)) - CURV_CONST
           - $signed(SUM_W'(c4_q)) + $signed(SUM_W'(c6_q));
    end
  end

  always_comb begin
    nums_w.rho   = bias_sm(sr_q);
    nums_w.slope = bias_sm(ss_q);
    nums_w.curv  = bias_sm(sc_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tag6_q <= tag_i;
      qr_q <= TERM_W'(pow_i.u2) * TERM_W'(C_QUAD_RHO);
      qs_q <= TERM_W'(pow_i.u)  * TERM_W'(C_QUAD_SLOPE);
      r2_q <= TERM_W'(pow_i.u2) * TERM_W'(C_R2);
      r4_q <= TERM_W'(pow_i.u4) * TERM_W'(C_R4);
      r6_q <= TERM_W'(pow_i.u6) * TERM_W'(C_R6);
      r8_q <= TERM_W'(pow_i.u8) * TERM_W'(C_R8);
      s1_q <= TERM_W'(pow_i.u)  * TERM_W'(C_S1);
      s3_q <= TERM_W'(pow_i.u3) * TERM_W'(C_S3);
      s5_q <= TERM_W'(pow_i.u5) * TERM_W'(C_S5);
      s7_q <= TERM_W'(pow_i.u7) * TERM_W'(C_S7);
      c2_q <= TERM_W'(pow_i.u2) * TERM_W'(C_C2);
      c4_q <= TERM_W'(pow_i.u4) * TERM_W'(C_C4);
      c6_q <= TERM_W'(pow_i.u6) * TERM_W'(C_C6);
    end
    if (en_i[1]) begin
      tag7_q <= tag6_q;
      sr_q   <= sr_w;
      ss_q   <= ss_w;
      sc_q   <= sc_w;
    end
    if (en_i[2]) begin
      tag8_q <= tag7_q;
      nums_q <= nums_w;
    end
  end

  assign tag_o  = tag8_q;
  assign nums_o = nums_q;

endmodule

// File: rtl/qorp_div_lane.sv
// ----------------------------------------------------------------------------
// qorp_div_lane
// Rounded division of a biased magnitude by 3250 over four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qorp_div_lane import qorp_pkg::*; (
  input  logic       clk_i,
  input  logic [3:0] en_i,
  input  dividend_t  num_i,
  output quot_t      quot_o
);

  localparam int HI_W   = NUM_W - DIV_SPLIT;
  localparam int PP_W   = HI_W + DIV_RECIP_W;
  localparam int FULL_W = PP_W + DIV_SPLIT;
  localparam int PRD_W  = NUM_W + 1;

  logic [PP_W-1:0]   pp_hi_q, pp_lo_q;
  logic [NUM_W-1:0]  num9_q, num10_q, num11_q;
  logic              sign9_q, sign10_q, sign11_q, sign12_q;
  logic [FULL_W-1:0] full_w;
  logic [QUO_W-1:0]  qe10_q, qe11_q, q12_q;
  logic [PRD_W-1:0]  prod11_q;
  logic [PRD_W-1:0]  rem_w;
  logic [QUO_W-1:0]  q_w;

  always_comb begin
    full_w = (FULL_W'(pp_hi_q) << DIV_SPLIT) + FULL_W'(pp_lo_q);
    rem_w  = PRD_W'(num11_q) - prod11_q;
    q_w    = qe11_q + QUO_W'(rem_w >= PRD_W'(DIVISOR));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sign9_q <= num_i.sign;
      num9_q  <= num_i.num;
      pp_hi_q <= PP_W'(num_i.num[NUM_W-1:DIV_SPLIT]) * PP_W'(DIV_RECIP);
      pp_lo_q <= PP_W'(num_i.num[DIV_SPLIT-1:0]) * PP_W'(DIV_RECIP);
    end
    if (en_i[1]) begin
      sign10_q <= sign9_q;
      num10_q  <= num9_q;
      qe10_q   <= full_w[DIV_SHIFT +: QUO_W];
    end
    if (en_i[2]) begin
      sign11_q <= sign10_q;
      num11_q  <= num10_q;
      qe11_q   <= qe10_q;
      prod11_q <= PRD_W'(qe10_q) * PRD_W'(DIVISOR);
    end
    if (en_i[3]) begin
      sign12_q <= sign11_q;
      q12_q    <= q_w;
    end
  end

  assign quot_o = '{sign: sign12_q, mag: q12_q};

endmodule

// File: rtl/qorp_scale_out.sv
// ----------------------------------------------------------------------------
// qorp_scale_out
// Clamps rho, scales psi by 1/cc and curvature twice by 1/cc, saturates, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qorp_scale_out import qorp_pkg::*; (
  input  logic                         clk_i,
  input  logic [2:0]                   en_i,
  input  tag_t                         tag_i,
  input  quot_t                        rho_i,
  input  quot_t                        slope_i,
  input  quot_t                        curv_i,
  input  logic [CFG_WIDTH-1:0]         tuning_recip_i,
  output logic [LOSS_WIDTH-1:0]        loss_value_o,
  output logic signed [DATA_WIDTH-1:0] slope_value_o,
  output logic signed [DATA_WIDTH-1:0] curvature_value_o,
  output region_e                      region_o,
  output logic                         clipped_o
);

  localparam int SP_W = QUO_W + CFG_WIDTH;
  localparam int C2_W = M1_W + CFG_WIDTH;

  tag_t                  tag13_q, tag14_q;
  logic [LOSS_WIDTH-1:0] loss13_q, loss14_q;
  logic                  psi_neg13_q, psi_neg14_q;
  logic [M1_W-1:0]       psi13_q, psi14_q;
  logic                  curv_neg13_q, curv_neg14_q;
  logic [M1_W-1:0]       curv13_q;
  logic [MAG_W-1:0]      curv14_q;

  logic [LOSS_WIDTH-1:0] loss_w;
  logic [SP_W-1:0]       psi_prod_w, curv_prod_w;
  logic [C2_W-1:0]       curv2_prod_w;
  logic [DATA_WIDTH:0]   psi_sat_w, curv_sat_w;

  logic [LOSS_WIDTH-1:0] loss_q;
  logic [DATA_WIDTH-1:0] slope_q, curv_q;
  region_e               region_q;
  logic                  clipped_q;

  // returns {clip, value}
  function automatic logic [DATA_WIDTH:0] saturate_sm(input logic neg,
                                                      input logic [MAG_W-1:0] mag);
    logic [DATA_WIDTH:0] res;
    if (!neg) begin
      if (mag > MAG_W'(SAT_POS)) begin
        res = {1'b1, SAT_POS};
      end else begin
        res = {1'b0, mag[DATA_WIDTH-1:0]};
      end
    end else begin
      if (mag > MAG_W'(SAT_NEG)) begin
        res = {1'b1, SAT_NEG};
      end else begin
        res = {1'b0, ~mag[DATA_WIDTH-1:0] + DATA_WIDTH'(1)};
      end
    end
    return res;
  endfunction

  always_comb begin
    if (rho_i.sign) begin
      loss_w = '0;
    end else if (rho_i.mag > QUO_W'(LOSS_ONE)) begin
      loss_w = LOSS_ONE;
    end else begin
      loss_w = rho_i.mag[LOSS_WIDTH-1:0];
    end
    psi_prod_w   = SP_W'(slope_i.mag) * SP_W'(tuning_recip_i) + SP_W'(HALF_LSB);
    curv_prod_w  = SP_W'(curv_i.mag) * SP_W'(tuning_recip_i) + SP_W'(HALF_LSB);
    curv2_prod_w = C2_W'(curv13_q) * C2_W'(tuning_recip_i) + C2_W'(HALF_LSB);
    psi_sat_w    = saturate_sm(psi_neg14_q, MAG_W'(psi14_q));
    curv_sat_w   = saturate_sm(curv_neg14_q, curv14_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      tag13_q      <= tag_i;
      loss13_q     <= loss_w;
      psi_neg13_q  <= tag_i.neg ^ slope_i.sign;
      psi13_q      <= psi_prod_w[FRAC_BITS +: M1_W];
      curv_neg13_q <= curv_i.sign;
      curv13_q     <= curv_prod_w[FRAC_BITS +: M1_W];
    end
    if (en_i[1]) begin
      tag14_q      <= tag13_q;
      loss14_q     <= loss13_q;
      psi_neg14_q  <= psi_neg13_q;
      psi14_q      <= psi13_q;
      curv_neg14_q <= curv_neg13_q;
      curv14_q     <= curv2_prod_w[FRAC_BITS +: MAG_W];
    end
    if (en_i[2]) begin
      region_q <= tag14_q.region;
      if (tag14_q.region == REGION_FLAT) begin
        loss_q    <= LOSS_ONE;
        slope_q   <= '0;
        curv_q    <= '0;
        clipped_q <= 1'b0;
      end else begin
        loss_q    <= loss14_q;
        slope_q   <= psi_sat_w[DATA_WIDTH-1:0];
        curv_q    <= curv_sat_w[DATA_WIDTH-1:0];
        clipped_q <= psi_sat_w[DATA_WIDTH] | curv_sat_w[DATA_WIDTH];
      end
    end
  end

  assign loss_value_o      = loss_q;
  assign slope_value_o     = $signed(slope_q);
  assign curvature_value_o = $signed(curv_q);
  assign region_o          = region_q;
  assign clipped_o         = clipped_q;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the quasi-optimal loss evaluator. A queue-fed
// driver sends residuals in bursts; a monitor stalls on a random pattern and
// compares every result field against an in-bench fixed-point model, across
// several tuning settings written between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import qorp_pkg::*;

  localparam int          LIMIT_CYCLES = 300000;
  localparam int          DRAIN_CYCLES = STAGES + 5;
  localparam int          PRINT_CAP    = 40;
  localparam longint      SAT_HI       = (longint'(1) << (DATA_WIDTH - 1)) - 1;
  localparam longint      SAT_LO       = -(longint'(1) << (DATA_WIDTH - 1));
  localparam logic [63:0] MUL_CAP      = (64'd1 << 40) - 1;
  localparam longint      MAG_MAX      = longint'(1) << (DATA_WIDTH - 1);
  localparam logic [CFG_WIDTH-1:0] CFG_MAX = {CFG_WIDTH{1'b1}};

  typedef struct {
    logic signed [DATA_WIDTH-1:0] residual;
    logic [LOSS_WIDTH-1:0]        loss;
    logic signed [DATA_WIDTH-1:0] slope;
    logic signed [DATA_WIDTH-1:0] curv;
    region_e                      region;
    logic                         clipped;
  } loss_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic signed [DATA_WIDTH-1:0] residual_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [LOSS_WIDTH-1:0]        loss_value_o;
  logic signed [DATA_WIDTH-1:0] slope_value_o;
  logic signed [DATA_WIDTH-1:0] curvature_value_o;
  logic [1:0]                   region_o;
  logic                         clipped_o;
  logic                         cfg_we_i = 1'b0;
  logic                         cfg_idx_i = CFG_TUNING_CONST;
  logic [CFG_WIDTH-1:0]         cfg_wdata_i = '0;

  logic signed [DATA_WIDTH-1:0] residual_q[$];
  loss_result_t                 loss_expect_q[$];
  logic [CFG_WIDTH-1:0]         cc_reg  = CFG_RESET;
  logic [CFG_WIDTH-1:0]         rcp_reg = CFG_RESET;
  int                           errors = 0;
  int                           cycle_count = 0;
  int                           burst_left = 0;
  int                           gap_left = 0;
  int                           stall_window = 0;
  int                           stall_pct = 0;
  loss_result_t                 head_exp;

  quasi_optimal_rho_psi_eval_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .residual_i        (residual_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .loss_value_o      (loss_value_o),
    .slope_value_o     (slope_value_o),
    .curvature_value_o (curvature_value_o),
    .region_o          (region_o),
    .clipped_o         (clipped_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---- fixed-point loss model ----
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'(HALF_LSB)) >> FRAC_BITS;
  endfunction

  function automatic longint div_round(longint n);
    longint m;
    m = (n < 0) ? -n : n;
    m = (m + DIVISOR / 2) / DIVISOR;
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint scale_recip(longint a, logic [CFG_WIDTH-1:0] rcp);
    logic [63:0] m;
    m = (a < 0) ? 64'(-a) : 64'(a);
    if (m > MUL_CAP) m = MUL_CAP;
    m = (m * 64'(rcp) + 64'(HALF_LSB)) >> FRAC_BITS;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_data(longint v);
    return (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
  endfunction

  function automatic loss_result_t predict_loss(logic signed [DATA_WIDTH-1:0] x,
                                                logic [CFG_WIDTH-1:0] cc,
                                                logic [CFG_WIDTH-1:0] rcp);
    loss_result_t r;
    logic [63:0]  ax, c, u, u2, u3, u4, u5, u6, u7, u8;
    longint       one, nr, nd, nc, rho, psi, curv;
    bit           neg;
    one = longint'(1) << FRAC_BITS;
    neg = x[DATA_WIDTH-1];
    ax  = neg ? 64'(-longint'(x)) : 64'(longint'(x));
    c   = 64'(cc);
    r.residual = x;
    r.clipped  = 1'b0;
    if (ax <= 2 * c) r.region = REGION_QUAD;
    else if (ax <= 3 * c) r.region = REGION_POLY;
    else r.region = REGION_FLAT;
    if (r.region == REGION_FLAT) begin
      r.loss  = LOSS_ONE;
      r.slope = '0;
      r.curv  = '0;
      return r;
    end
    u = qmul(ax, 64'(rcp));
    if (u > 64'(U_CAP)) u = 64'(U_CAP);
    u2 = qmul(u, u);
    u3 = qmul(u2, u);
    u4 = qmul(u2, u2);
    u5 = qmul(u4, u);
    u6 = qmul(u4, u2);
    u7 = qmul(u4, u3);
    u8 = qmul(u4, u4);
    if (r.region == REGION_QUAD) begin
      nr = 500 * longint'(u2);
      nd = 1000 * longint'(u);
      nc = 1000 * one;
    end else begin
      nr = 1792 * one - 972 * longint'(u2) + 432 * longint'(u4)
         - 52 * longint'(u6) + 2 * longint'(u8);
      nd = -1944 * longint'(u) + 1728 * longint'(u3) - 312 * longint'(u5)
         + 16 * longint'(u7);
      nc = -1944 * one + 5184 * longint'(u2) - 1560 * longint'(u4)
         + 112 * longint'(u6);
    end
    rho = div_round(nr);
    if (rho < 0) rho = 0;
    if (rho > one) rho = one;
    psi = scale_recip(div_round(nd), rcp);
    if (neg) psi = -psi;
    curv = scale_recip(scale_recip(div_round(nc), rcp), rcp);
    r.loss    = LOSS_WIDTH'(rho);
    r.clipped = (clamp_data(psi) != psi) || (clamp_data(curv) != curv);
    r.slope   = DATA_WIDTH'(clamp_data(psi));
    r.curv    = DATA_WIDTH'(clamp_data(curv));
    return r;
  endfunction

  // ---- stimulus helpers ----
  function automatic logic signed [DATA_WIDTH-1:0] to_residual(longint mag, bit neg);
    if (mag > MAG_MAX) mag = MAG_MAX;
    if (!neg && mag == MAG_MAX) mag = MAG_MAX - 1;
    return DATA_WIDTH'(neg ? -mag : mag);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pick_residual(logic [CFG_WIDTH-1:0] cc);
    int unsigned sel;
    int unsigned k;
    longint      c, mag;
    bit          neg;
    c   = longint'(cc);
    sel = $urandom_range(0, 99);
    neg = $urandom_range(0, 1);
    if (sel < 25) return DATA_WIDTH'($urandom);
    if (sel < 70) begin
      mag = longint'($urandom_range(0, 32'(3 * c + c / 4)));
    end else if (sel < 85) begin
      case ($urandom_range(0, 5))
        0:       mag = 2 * c - 1;
        1:       mag = 2 * c;
        2:       mag = 2 * c + 1;
        3:       mag = 3 * c - 1;
        4:       mag = 3 * c;
        default: mag = 3 * c + 1;
      endcase
    end else begin
      k   = $urandom_range(0, DATA_WIDTH);
      mag = longint'($urandom) & ((longint'(1) << k) - 1);
    end
    return to_residual(mag, neg);
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < PRINT_CAP) $display("MISMATCH @%0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (residual_q.size() != 0 || in_valid_i || loss_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TUNING_CONST) cc_reg = val;
    else rcp_reg = val;
  endtask

  task automatic run_phase(logic [CFG_WIDTH-1:0] cc, logic [CFG_WIDTH-1:0] rcp, int n);
    wait_idle();
    write_reg(CFG_TUNING_CONST, cc);
    write_reg(CFG_TUNING_RECIP, rcp);
    @(negedge clk_i);
    repeat (n) residual_q.push_back(pick_residual(cc));
  endtask

  // ---- driver ----
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        loss_expect_q.push_back(predict_loss(residual_i, cc_reg, rcp_reg));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (residual_q.size() != 0) begin
          residual_i <= residual_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (loss_expect_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          head_exp = loss_expect_q.pop_front();
          if (loss_value_o !== head_exp.loss)
            report_mismatch($sformatf("x=%0d loss_value %0d, expected %0d",
                            head_exp.residual, loss_value_o, head_exp.loss));
          if (slope_value_o !== head_exp.slope)
            report_mismatch($sformatf("x=%0d slope_value %0d, expected %0d",
                            head_exp.residual, slope_value_o, head_exp.slope));
          if (curvature_value_o !== head_exp.curv)
            report_mismatch($sformatf("x=%0d curvature_value %0d, expected %0d",
                            head_exp.residual, curvature_value_o, head_exp.curv));
          if (region_o !== head_exp.region)
            report_mismatch($sformatf("x=%0d region %0d, expected %0d",
                            head_exp.residual, region_o, head_exp.region));
          if (clipped_o !== head_exp.clipped)
            report_mismatch($sformatf("x=%0d clipped %0d, expected %0d",
                            head_exp.residual, clipped_o, head_exp.clipped));
        end
      end
      if (stall_window == 0) begin
        stall_window = $urandom_range(20, 80);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end else begin
        stall_window--;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles", cycle_count);
    $display("** quasi_optimal_rho_psi_eval_top: FAILED **");
    $finish;
  end

  // ---- sequence ----
  initial begin
    logic [CFG_WIDTH-1:0] cc, rcp;
    longint               c;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes and zone edges at reset tuning
    @(negedge clk_i);
    c = longint'(cc_reg);
    residual_q.push_back(to_residual(0, 1'b0));
    residual_q.push_back(to_residual(1, 1'b0));
    residual_q.push_back(to_residual(1, 1'b1));
    residual_q.push_back(to_residual(MAG_MAX, 1'b0));
    residual_q.push_back(to_residual(MAG_MAX, 1'b1));
    for (int s = 0; s < 2; s++) begin
      residual_q.push_back(to_residual(c, s));
      residual_q.push_back(to_residual(2 * c, s));
      residual_q.push_back(to_residual(2 * c + 1, s));
      residual_q.push_back(to_residual(3 * c, s));
      residual_q.push_back(to_residual(3 * c + 1, s));
      residual_q.push_back(to_residual(c * 7 / 2, s));
    end

    // register extremes, then an inconsistent reciprocal that clips
    run_phase(CFG_RESET, CFG_RESET, 60);
    run_phase(CFG_WIDTH'(1), CFG_MAX, 90);
    run_phase(CFG_MAX, CFG_WIDTH'(1), 90);
    run_phase(CFG_RESET, CFG_MAX, 100);
    run_phase(CFG_MAX, CFG_MAX, 90);

    // random tuning, mostly with a matching reciprocal
    for (int p = 0; p < 6; p++) begin
      cc  = CFG_WIDTH'($urandom_range(512, 32'(CFG_MAX)));
      c   = (longint'(1) << 32) / longint'(cc);
      rcp = (c > longint'(CFG_MAX)) ? CFG_MAX : CFG_WIDTH'(c);
      if ($urandom_range(0, 3) == 0) rcp = CFG_WIDTH'($urandom_range(1, 32'(CFG_MAX)));
      run_phase(cc, rcp, 85);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("** quasi_optimal_rho_psi_eval_top: PASSED **");
    end else begin
      $display("** quasi_optimal_rho_psi_eval_top: FAILED **");
    end
    $finish;
  end

endmodule
